// File: sv/bmc_pkg.sv
// Shared types, constants and the byte substitution table for the byte mix block cipher.
package bmc_pkg;

  localparam int unsigned HALF_W     = 64;
  localparam int unsigned KEY_W      = 2 * HALF_W;
  localparam int unsigned KEY_COUNT  = 10;
  localparam int unsigned KEY_IDX_W  = $clog2(KEY_COUNT);
  localparam int unsigned ROUNDS_DEF = 10;
  localparam int unsigned HROT_W     = 6;
  localparam int unsigned LROT_W     = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [HROT_W-1:0] HALF_ROT_RST = HROT_W'(13);
  localparam logic [LROT_W-1:0] LANE_ROT_RST = LROT_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1,
    CFG_HALF_ROT = 2'd2,
    CFG_LANE_ROT = 2'd3
  } bmc_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_HOLD
  } bmc_state_e;

  typedef struct packed {
    logic                 en;
    logic [KEY_IDX_W-1:0] addr;
    logic [KEY_W-1:0]     data;
  } bmc_key_wr_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [KEY_W-1:0] sub_word(input logic [KEY_W-1:0] w);
    logic [KEY_W-1:0] r;
    r = '0;
    for (int i = 0; i < KEY_W / 8; i++) begin
      r[8*i +: 8] = SBOX[w[8*i +: 8]];
    end
    return r;
  endfunction

endpackage

// File: sv/bmc_req_if.sv
// Request channel: operation selector and the two block halves.
interface bmc_req_if import bmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [HALF_W-1:0] block_low;
  logic [HALF_W-1:0] block_high;

  modport source (output valid, op, block_low, block_high, input ready);
  modport sink   (input valid, op, block_low, block_high, output ready);
endinterface

// File: sv/bmc_rsp_if.sv
// Response channel: the two halves of the processed block.
interface bmc_rsp_if import bmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] result_low;
  logic [HALF_W-1:0] result_high;

  modport source (output valid, result_low, result_high, input ready);
  modport sink   (input valid, result_low, result_high, output ready);
endinterface

// File: sv/byte_mix_block_cipher.sv
// Top level of the byte mix block cipher: config registers, round sequencer, output register.
//
//   channel   direction  handshake          payload
//   req_i     in         valid / ready      op, block_low, block_high
//   rsp_o     out        valid / ready      result_low, result_high
//   cfg       in         cfg_we_i only      cfg_idx_i, cfg_wdata_i
//
// An item is taken in ST_IDLE, which also starts the first round key read; then each round
// goes through the single round unit in ST_ROUND, with its round key read from the key RAM
// ahead of it. A new request can be taken once the sequencer is back in ST_IDLE.
// After reset, and after any write of key_low or key_high, the key generator fills all
// KEY_COUNT (10) key RAM entries; requests wait meanwhile, config writes are taken as ever.
// A finished block goes to the output register; if that still holds an untaken result, the
// block waits in the round register and no new request is taken until it moves out.
module byte_mix_block_cipher import bmc_pkg::*; #(
  parameter int unsigned ROUNDS = ROUNDS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bmc_req_if.sink               req_i,
  bmc_rsp_if.source             rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam logic [KEY_IDX_W-1:0] LastIdx = KEY_IDX_W'(ROUNDS - 1);

  // Configuration registers
  logic [HALF_W-1:0] key_low_q, key_high_q;
  logic [HROT_W-1:0] half_rot_q;
  logic [LROT_W-1:0] lane_rot_q;
  logic              key_restart;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      half_rot_q <= HALF_ROT_RST;
      lane_rot_q <= LANE_ROT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY_LOW:  key_low_q  <= cfg_wdata_i[HALF_W-1:0];
        CFG_KEY_HIGH: key_high_q <= cfg_wdata_i[HALF_W-1:0];
        CFG_HALF_ROT: half_rot_q <= cfg_wdata_i[HROT_W-1:0];
        CFG_LANE_ROT: lane_rot_q <= cfg_wdata_i[LROT_W-1:0];
        default:      ;
      endcase
    end
  end

  // Any key write restarts the schedule; the new key is in place by the next cycle.
  assign key_restart = cfg_we_i &&
                       (cfg_idx_i == CFG_KEY_LOW || cfg_idx_i == CFG_KEY_HIGH);

  // Key schedule and round key RAM
  logic                 sched_busy;
  bmc_key_wr_t          key_wr;
  logic [KEY_IDX_W-1:0] key_raddr;
  logic [KEY_W-1:0]     round_key;

  bmc_key_sched u_key_sched (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (key_restart),
    .key_low_i  (key_low_q),
    .key_high_i (key_high_q),
    .busy_o     (sched_busy),
    .wr_o       (key_wr)
  );

  bmc_ram #(
    .Width (KEY_W),
    .Depth (KEY_COUNT)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_wr.en),
    .waddr_i (key_wr.addr),
    .wdata_i (key_wr.data),
    .raddr_i (key_raddr),
    .rdata_o (round_key)
  );

  // Round sequencer
  bmc_state_e           state_q, state_d;
  logic                 op_q;
  logic [KEY_IDX_W-1:0] key_idx_q;
  logic [HALF_W-1:0]    st_lo_q, st_hi_q;
  logic [HALF_W-1:0]    rnd_lo, rnd_hi;
  logic                 out_valid_q;
  logic [HALF_W-1:0]    out_lo_q, out_hi_q;

  logic req_take;
  logic last_round;
  logic out_free;
  logic out_load;

  assign req_take   = req_i.valid && req_i.ready;
  assign last_round = op_q ? (key_idx_q == '0) : (key_idx_q == LastIdx);
  assign out_free   = !out_valid_q || rsp_o.ready;

  bmc_round u_round (
    .dec_i      (op_q),
    .half_rot_i (half_rot_q),
    .lane_rot_i (lane_rot_q),
    .lo_i       (st_lo_q),
    .hi_i       (st_hi_q),
    .key_i      (round_key),
    .lo_o       (rnd_lo),
    .hi_o       (rnd_hi)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_take) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (last_round) begin
          state_d = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: request ready, key read address, output load
  always_comb begin
    req_i.ready = 1'b0;
    key_raddr   = key_idx_q;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_i.ready = !sched_busy;
        // Fetch the first round key now so it is there in the first round cycle.
        key_raddr   = req_i.op ? LastIdx : '0;
      end
      ST_ROUND: begin
        key_raddr = op_q ? (key_idx_q - KEY_IDX_W'(1)) : (key_idx_q + KEY_IDX_W'(1));
        out_load  = last_round && out_free;
      end
      ST_HOLD: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Block state and key index: load on request, advance one round per cycle.
  always_ff @(posedge clk_i) begin
    if (req_take) begin
      op_q      <= req_i.op;
      key_idx_q <= req_i.op ? LastIdx : '0;
      st_lo_q   <= req_i.block_low;
      st_hi_q   <= req_i.block_high;
    end else if (state_q == ST_ROUND) begin
      key_idx_q <= key_raddr;
      st_lo_q   <= rnd_lo;
      st_hi_q   <= rnd_hi;
    end
  end

  // Output register: take the last round directly, or the held block from ST_HOLD.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_lo_q <= (state_q == ST_ROUND) ? rnd_lo : st_lo_q;
      out_hi_q <= (state_q == ST_ROUND) ? rnd_hi : st_hi_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.result_low  = out_lo_q;
  assign rsp_o.result_high = out_hi_q;

`ifndef SYNTHESIS
  a_take_starts_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_take |=> state_q == ST_ROUND)
    else $error("request taken without entering the round loop");

  a_dec_starts_last_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_take && req_i.op) |=> key_idx_q == LastIdx)
    else $error("decrypt did not start at the last round key");

  a_key_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROUND |-> key_idx_q <= LastIdx)
    else $error("round key index out of range");

  a_result_from_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_ROUND || state_q == ST_HOLD))
    else $error("result appeared without a finished block");
`endif

endmodule

// File: sv/bmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmc_ram import bmc_pkg::*; #(
  parameter int unsigned Width = KEY_W,
  parameter int unsigned Depth = KEY_COUNT
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/bmc_key_sched.sv
// Round key generator: one S-box pass over the 128-bit key word per cycle while busy.
module bmc_key_sched import bmc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              restart_i,
  input  logic [HALF_W-1:0] key_low_i,
  input  logic [HALF_W-1:0] key_high_i,
  output logic              busy_o,
  output bmc_key_wr_t       wr_o
);

  localparam logic [KEY_IDX_W-1:0] LastIdx = KEY_IDX_W'(KEY_COUNT - 1);

  logic                 busy_q, busy_d;
  logic [KEY_IDX_W-1:0] idx_q, idx_d;
  logic [KEY_W-1:0]     cur_q, cur_d;
  logic [KEY_W-1:0]     next_key;

  // First key comes from the configured key, later ones from the previous key.
  assign next_key = sub_word((idx_q == '0) ? {key_high_i, key_low_i} : cur_q);

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    cur_d  = cur_q;
    if (restart_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (busy_q) begin
      cur_d = next_key;
      idx_d = idx_q + KEY_IDX_W'(1);
      if (idx_q == LastIdx) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  assign busy_o  = busy_q;
  assign wr_o.en   = busy_q && !restart_i;
  assign wr_o.addr = idx_q;
  assign wr_o.data = next_key;

endmodule

// File: sv/bmc_round.sv
// Round datapath: one full encrypt or decrypt round on both halves.
module bmc_round import bmc_pkg::*; (
  input  logic              dec_i,
  input  logic [HROT_W-1:0] half_rot_i,
  input  logic [LROT_W-1:0] lane_rot_i,
  input  logic [HALF_W-1:0] lo_i,
  input  logic [HALF_W-1:0] hi_i,
  input  logic [KEY_W-1:0]  key_i,
  output logic [HALF_W-1:0] lo_o,
  output logic [HALF_W-1:0] hi_o
);

  function automatic logic [HALF_W-1:0] rotl(input logic [HALF_W-1:0] x,
                                             input logic [HROT_W-1:0] d);
    logic [2*HALF_W-1:0] t;
    t = {x, x} << d;
    return t[2*HALF_W-1:HALF_W];
  endfunction

  function automatic logic [HALF_W-1:0] rotr(input logic [HALF_W-1:0] x,
                                             input logic [HROT_W-1:0] d);
    logic [2*HALF_W-1:0] t;
    t = {x, x} >> d;
    return t[HALF_W-1:0];
  endfunction

  function automatic logic [HALF_W-1:0] lanes_rot(input logic [HALF_W-1:0] x,
                                                  input logic [LROT_W-1:0] d,
                                                  input logic left);
    logic [HALF_W-1:0] r;
    logic [31:0]       t;
    r = '0;
    for (int i = 0; i < HALF_W / 16; i++) begin
      if (left) begin
        t = {x[16*i +: 16], x[16*i +: 16]} << d;
        r[16*i +: 16] = t[31:16];
      end else begin
        t = {x[16*i +: 16], x[16*i +: 16]} >> d;
        r[16*i +: 16] = t[15:0];
      end
    end
    return r;
  endfunction

  function automatic logic [HALF_W-1:0] bytes_add(input logic [HALF_W-1:0] a,
                                                  input logic [HALF_W-1:0] b);
    logic [HALF_W-1:0] r;
    for (int i = 0; i < HALF_W / 8; i++) begin
      r[8*i +: 8] = a[8*i +: 8] + b[8*i +: 8];
    end
    return r;
  endfunction

  function automatic logic [HALF_W-1:0] bytes_sub(input logic [HALF_W-1:0] a,
                                                  input logic [HALF_W-1:0] b);
    logic [HALF_W-1:0] r;
    for (int i = 0; i < HALF_W / 8; i++) begin
      r[8*i +: 8] = a[8*i +: 8] - b[8*i +: 8];
    end
    return r;
  endfunction

  function automatic logic [HALF_W-1:0] enc_half(input logic [HALF_W-1:0] x,
                                                 input logic [HALF_W-1:0] k,
                                                 input logic [HROT_W-1:0] d);
    logic [HALF_W-1:0] a;
    a = rotl(x ^ k, d);
    a = rotl(bytes_add(a, k), d);
    a = ~(a ^ k);
    a = bytes_sub(a, k) ^ k;
    return a;
  endfunction

  function automatic logic [HALF_W-1:0] dec_half(input logic [HALF_W-1:0] x,
                                                 input logic [HALF_W-1:0] k,
                                                 input logic [HROT_W-1:0] d);
    logic [HALF_W-1:0] a;
    a = bytes_add(x ^ k, k);
    a = rotr(~a ^ k, d);
    a = rotr(bytes_sub(a, k), d);
    return a ^ k;
  endfunction

  logic [HALF_W-1:0] k_lo, k_hi;
  logic [HALF_W-1:0] enc_lo, enc_hi;
  logic [HALF_W-1:0] dec_lo, dec_hi;

  assign k_lo = key_i[HALF_W-1:0];
  assign k_hi = key_i[KEY_W-1:HALF_W];

  // Encrypt: mix each half, swap, then rotate the lanes.
  assign enc_lo = lanes_rot(enc_half(hi_i, k_hi, half_rot_i), lane_rot_i, 1'b1);
  assign enc_hi = lanes_rot(enc_half(lo_i, k_lo, half_rot_i), lane_rot_i, 1'b1);

  // Decrypt: undo the lane rotation and the swap, then unmix each half.
  assign dec_lo = dec_half(lanes_rot(hi_i, lane_rot_i, 1'b0), k_lo, half_rot_i);
  assign dec_hi = dec_half(lanes_rot(lo_i, lane_rot_i, 1'b0), k_hi, half_rot_i);

  assign lo_o = dec_i ? dec_lo : enc_lo;
  assign hi_o = dec_i ? dec_hi : enc_hi;

endmodule

// File: tb/bmc_cipher_check.sv
// Checker for the byte mix block cipher: predicts each block and compares the responses.
`timescale 1ns / 100ps

module bmc_cipher_check import bmc_pkg::*; #(
  parameter int unsigned ROUNDS = ROUNDS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bmc_req_if                    req_i,
  bmc_rsp_if                    rsp_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned           fail_cnt_o,
  output int unsigned           pending_o
);

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [HALF_W-1:0] lo;
    logic [HALF_W-1:0] hi;
  } block_t;

  // Predictor copy of the configuration and the key schedule.
  logic [HALF_W-1:0] key_lo;
  logic [HALF_W-1:0] key_hi;
  logic [HROT_W-1:0] half_rot;
  logic [LROT_W-1:0] lane_rot;
  logic [HALF_W-1:0] round_key_lo [KEY_COUNT];
  logic [HALF_W-1:0] round_key_hi [KEY_COUNT];

  block_t      expected_blocks [$];
  block_t      want;
  int unsigned fail_cnt;
  int unsigned report_cnt;

  function automatic logic [HALF_W-1:0] sbox_half(input logic [HALF_W-1:0] w);
    logic [HALF_W-1:0] r;
    for (int i = 0; i < HALF_W / 8; i++) r[8*i +: 8] = SBOX[w[8*i +: 8]];
    return r;
  endfunction

  function automatic void build_round_keys();
    logic [HALF_W-1:0] lo;
    logic [HALF_W-1:0] hi;
    lo = key_lo;
    hi = key_hi;
    for (int i = 0; i < KEY_COUNT; i++) begin
      lo = sbox_half(lo);
      hi = sbox_half(hi);
      round_key_lo[i] = lo;
      round_key_hi[i] = hi;
    end
  endfunction

  function automatic logic [HALF_W-1:0] half_rol(input logic [HALF_W-1:0] x);
    logic [2*HALF_W-1:0] w;
    w = {x, x};
    return w[(2*HALF_W-1-half_rot) -: HALF_W];
  endfunction

  function automatic logic [HALF_W-1:0] half_ror(input logic [HALF_W-1:0] x);
    logic [2*HALF_W-1:0] w;
    w = {x, x};
    return w[half_rot +: HALF_W];
  endfunction

  function automatic logic [HALF_W-1:0] lane_rot_half(input logic [HALF_W-1:0] x,
                                                      input logic left);
    logic [31:0]       w;
    logic [HALF_W-1:0] r;
    for (int i = 0; i < 4; i++) begin
      w = {x[16*i +: 16], x[16*i +: 16]};
      r[16*i +: 16] = left ? w[(31-lane_rot) -: 16] : w[lane_rot +: 16];
    end
    return r;
  endfunction

  function automatic logic [HALF_W-1:0] byte_add(input logic [HALF_W-1:0] a,
                                                 input logic [HALF_W-1:0] b);
    logic [HALF_W-1:0] r;
    for (int i = 0; i < HALF_W / 8; i++) r[8*i +: 8] = a[8*i +: 8] + b[8*i +: 8];
    return r;
  endfunction

  function automatic logic [HALF_W-1:0] byte_sub(input logic [HALF_W-1:0] a,
                                                 input logic [HALF_W-1:0] b);
    logic [HALF_W-1:0] r;
    for (int i = 0; i < HALF_W / 8; i++) r[8*i +: 8] = a[8*i +: 8] - b[8*i +: 8];
    return r;
  endfunction

  function automatic block_t cipher_block(input logic decrypt,
                                          input logic [HALF_W-1:0] lo_in,
                                          input logic [HALF_W-1:0] hi_in);
    logic [HALF_W-1:0] a;
    logic [HALF_W-1:0] b;
    logic [HALF_W-1:0] t;
    logic [HALF_W-1:0] kl;
    logic [HALF_W-1:0] kh;
    int unsigned       n;
    int unsigned       k;
    block_t            r;
    n = (ROUNDS > KEY_COUNT) ? KEY_COUNT : ROUNDS;
    a = lo_in;
    b = hi_in;
    for (int i = 0; i < n; i++) begin
      k  = decrypt ? n - 1 - i : i;
      kl = round_key_lo[k];
      kh = round_key_hi[k];
      if (!decrypt) begin
        a = half_rol(a ^ kl);     b = half_rol(b ^ kh);
        a = byte_add(a, kl);      b = byte_add(b, kh);
        a = ~(half_rol(a) ^ kl);  b = ~(half_rol(b) ^ kh);
        a = byte_sub(a, kl) ^ kl; b = byte_sub(b, kh) ^ kh;
        t = a;
        a = lane_rot_half(b, 1'b1);
        b = lane_rot_half(t, 1'b1);
      end else begin
        t = lane_rot_half(a, 1'b0);
        a = lane_rot_half(b, 1'b0);
        b = t;
        a = byte_add(a ^ kl, kl); b = byte_add(b ^ kh, kh);
        a = half_ror(~a ^ kl);    b = half_ror(~b ^ kh);
        a = half_ror(byte_sub(a, kl)) ^ kl;
        b = half_ror(byte_sub(b, kh)) ^ kh;
      end
    end
    r.lo = a;
    r.hi = b;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo     = '0;
      key_hi     = '0;
      half_rot   = HALF_ROT_RST;
      lane_rot   = LANE_ROT_RST;
      build_round_keys();
      expected_blocks.delete();
      fail_cnt   = 0;
      report_cnt = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_blocks.size() == 0) begin
          fail_cnt++;
          if (report_cnt < MAX_REPORTS) begin
            report_cnt++;
            $display("%0t: unexpected result %h_%h", $realtime, rsp_i.result_high,
                     rsp_i.result_low);
          end
        end else begin
          want = expected_blocks.pop_front();
          if (rsp_i.result_low !== want.lo || rsp_i.result_high !== want.hi) begin
            fail_cnt++;
            if (report_cnt < MAX_REPORTS) begin
              report_cnt++;
              $display("%0t: result mismatch low exp %h got %h, high exp %h got %h",
                       $realtime, want.lo, rsp_i.result_low, want.hi, rsp_i.result_high);
            end
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        expected_blocks.push_back(cipher_block(req_i.op, req_i.block_low, req_i.block_high));
      end
      if (cfg_we_i) begin
        case (bmc_cfg_e'(cfg_idx_i))
          CFG_KEY_LOW: begin
            key_lo = cfg_wdata_i;
            build_round_keys();
          end
          CFG_KEY_HIGH: begin
            key_hi = cfg_wdata_i;
            build_round_keys();
          end
          CFG_HALF_ROT: half_rot = cfg_wdata_i[HROT_W-1:0];
          CFG_LANE_ROT: lane_rot = cfg_wdata_i[LROT_W-1:0];
          default: ;
        endcase
      end
      fail_cnt_o <= fail_cnt;
      pending_o  <= expected_blocks.size();
    end
  end

endmodule

// File: tb/tb_byte_mix_block_cipher.sv
// Testbench top for the byte mix block cipher: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_byte_mix_block_cipher import bmc_pkg::*; ();

  localparam int unsigned ROUNDS       = ROUNDS_DEF;
  localparam logic        OP_ENC       = 1'b0;
  localparam logic        OP_DEC       = 1'b1;
  // Run limit, set well above the slowest legal run.
  localparam int unsigned CYCLE_LIMIT  = 900000;
  localparam int unsigned DRAIN_CYCLES = ROUNDS + 12;
  localparam int unsigned RAND_PHASES  = 11;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam logic [HALF_W-1:0] ONES   = '1;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  int unsigned           fail_cnt;
  int unsigned           pending_cnt;
  int unsigned           sent_cnt = 0;
  int unsigned           cycle_cnt = 0;
  bit                    held_off = 1'b0;

  bmc_req_if req_if ();
  bmc_rsp_if rsp_if ();

  byte_mix_block_cipher #(.ROUNDS(ROUNDS)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  bmc_cipher_check #(.ROUNDS(ROUNDS)) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending_cnt)
  );

  always #5 clk_i = ~clk_i;

  // Bound the run; a hung handshake ends here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly back-to-back requests, some short gaps, a few long ones.
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Random half: full random most of the time, else corner patterns that stress the
  // byte-wise carry handling (0x00, 0x7f, 0x80, 0xff bytes).
  function automatic logic [HALF_W-1:0] rand_half();
    logic [HALF_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: begin
        for (int i = 0; i < HALF_W / 8; i++) begin
          case ($urandom_range(0, 3))
            0:       v[8*i +: 8] = 8'h00;
            1:       v[8*i +: 8] = 8'h7f;
            2:       v[8*i +: 8] = 8'h80;
            default: v[8*i +: 8] = 8'hff;
          endcase
        end
      end
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // Offer one request and hold it until the block takes it. Called on a clock edge;
  // returns on the edge where the request was accepted.
  task automatic send_block(input logic op, input logic [HALF_W-1:0] lo,
                            input logic [HALF_W-1:0] hi, input int unsigned gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.op         <= op;
    req_if.block_low  <= lo;
    req_if.block_high <= hi;
    do @(posedge clk_i); while (!req_if.ready);
    sent_cnt++;
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain_pipe();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input bmc_cfg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic apply_setting(input logic [HALF_W-1:0] klo, input logic [HALF_W-1:0] khi,
                               input logic [HROT_W-1:0] hrot, input logic [LROT_W-1:0] lrot);
    write_reg(CFG_KEY_LOW, klo);
    write_reg(CFG_KEY_HIGH, khi);
    write_reg(CFG_HALF_ROT, CFG_DATA_W'(hrot));
    write_reg(CFG_LANE_ROT, CFG_DATA_W'(lrot));
  endtask

  // Response side: random ready with stalls of mixed length, plus one long hold-off
  // once HOLD_AT requests have been sent, so the block fills and blocks its input.
  initial begin : rsp_drain
    int unsigned r;
    int unsigned run;
    int unsigned hold_cnt;
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held_off && sent_cnt >= HOLD_AT) begin
        rsp_if.ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk_i);
        held_off = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          rsp_if.ready <= 1'b1;
          run = $urandom_range(1, 20);
        end else if (r < 95) begin
          rsp_if.ready <= 1'b0;
          run = $urandom_range(1, 3);
        end else begin
          rsp_if.ready <= 1'b0;
          run = $urandom_range(20, 60);
        end
        repeat (run) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    bit                quiet;
    logic [HROT_W-1:0] hrot;
    logic [LROT_W-1:0] lrot;
    req_if.valid      <= 1'b0;
    req_if.op         <= OP_ENC;
    req_if.block_low  <= '0;
    req_if.block_high <= '0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_KEY_LOW;
    cfg_wdata_i       <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings (schedule from the zero key), field extremes and byte carries.
    send_block(OP_ENC, '0, '0, 0);
    send_block(OP_DEC, '0, '0, 0);
    send_block(OP_ENC, ONES, ONES, 0);
    send_block(OP_DEC, ONES, ONES, 1);
    send_block(OP_ENC, 64'h8080_8080_8080_8080, 64'h7f7f_7f7f_7f7f_7f7f, 0);
    send_block(OP_DEC, 64'h7f7f_7f7f_7f7f_7f7f, 64'h8080_8080_8080_8080, 0);
    send_block(OP_ENC, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 2);
    send_block(OP_DEC, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 0);
    send_block(OP_ENC, 64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000, 0);
    drain_pipe();

    // Zero rotate amounts: both rotations become the identity.
    apply_setting(ONES, ONES, '0, '0);
    send_block(OP_ENC, 64'h0123_4567_89ab_cdef, 64'h0f0f_0f0f_f0f0_f0f0, 0);
    send_block(OP_DEC, 64'h0123_4567_89ab_cdef, 64'h0f0f_0f0f_f0f0_f0f0, 0);
    send_block(OP_ENC, ONES, '0, 0);
    send_block(OP_DEC, '0, ONES, 0);
    drain_pipe();

    // Largest rotate amounts, key bytes at the carry boundary.
    apply_setting(64'h8080_8080_8080_8080, 64'h7f7f_7f7f_7f7f_7f7f, '1, '1);
    send_block(OP_ENC, ONES, ONES, 0);
    send_block(OP_DEC, ONES, ONES, 0);
    send_block(OP_ENC, 64'hff00_ff00_ff00_ff00, 64'h00ff_00ff_00ff_00ff, 0);
    send_block(OP_DEC, 64'hff00_ff00_ff00_ff00, 64'h00ff_00ff_00ff_00ff, 0);
    drain_pipe();

    // Smallest nonzero rotate amounts with a random key.
    apply_setting({$urandom, $urandom}, {$urandom, $urandom}, 6'd1, 4'd1);
    send_block(OP_ENC, {$urandom, $urandom}, {$urandom, $urandom}, 0);
    send_block(OP_DEC, {$urandom, $urandom}, {$urandom, $urandom}, 0);
    send_block(OP_ENC, '0, ONES, 0);
    send_block(OP_DEC, ONES, '0, 0);

    // Random phases: fresh setting per phase, random requests with random gaps.
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      drain_pipe();
      case ($urandom_range(0, 7))
        0:       hrot = '0;
        1:       hrot = '1;
        2:       hrot = 6'd1;
        default: hrot = HROT_W'($urandom_range(0, 63));
      endcase
      case ($urandom_range(0, 7))
        0:       lrot = '0;
        1:       lrot = '1;
        2:       lrot = 4'd1;
        default: lrot = LROT_W'($urandom_range(0, 15));
      endcase
      apply_setting(rand_half(), rand_half(), hrot, lrot);
      // Run some phases with no sender gaps at all.
      quiet = ($urandom_range(0, 3) == 0);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        send_block($urandom_range(0, 1) ? OP_DEC : OP_ENC, rand_half(), rand_half(),
                   pick_gap(quiet));
      end
    end

    // Wait out the block, then allow for any stray result before the verdict.
    drain_pipe();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
